[rtl/biou_pkg.sv]
// Types and constants for the box intersection-over-union pipeline.
// No dependencies; used by box_intersection_over_union.
package biou_pkg;

  localparam int CoordW = 16;
  localparam int FracW  = 16;

  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int UniW   = ProdW + 2;
  localparam int RemW   = UniW - 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [FracW:0]           ratio_t;

  typedef struct packed {
    coord_t det_left;
    coord_t det_top;
    coord_t det_right;
    coord_t det_bottom;
    coord_t trk_left;
    coord_t trk_top;
    coord_t trk_right;
    coord_t trk_bottom;
  } in_word_t;

  typedef struct packed {
    ratio_t overlap_ratio;
    logic   ratio_invalid;
  } out_word_t;

  localparam ratio_t RatioOne  = ratio_t'(1) << FracW;
  localparam ratio_t RatioZero = '0;

endpackage

[rtl/box_intersection_over_union.sv]
// Streaming intersection-over-union of a detection box and a track box.
// Depends on biou_pkg for the word types and widths.
//
// One box pair word is taken in every clock cycle: busy is always low and
// start alone accepts a word. The result word is shown for one cycle on
// out_valid, in input order. The divider resolves one quotient bit per
// stage. It sits behind five registers for input capture, corner
// differences, the area multipliers, the union sum and the range check,
// and ahead of the output register. The receiver cannot stall the
// pipeline, so words must be taken when shown.
module box_intersection_over_union (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  biou_pkg::in_word_t  in_data,
  output logic                out_valid,
  output biou_pkg::out_word_t out_data
);

  localparam int DiffW = biou_pkg::DiffW;
  localparam int ProdW = biou_pkg::ProdW;
  localparam int UniW  = biou_pkg::UniW;
  localparam int RemW  = biou_pkg::RemW;
  localparam int FracW = biou_pkg::FracW;

  assign busy = 1'b0;

  // Input capture.
  logic               v1_r;
  biou_pkg::in_word_t in_r;

  // Corner differences.
  logic                    v2_r, v2_nxt;
  logic [DiffW-1:0]        iw_r, ih_r, iw_nxt, ih_nxt;
  logic signed [DiffW-1:0] dw_r, dh_r, tw_r, th_r;
  logic signed [DiffW-1:0] dw_nxt, dh_nxt, tw_nxt, th_nxt;

  // Products.
  logic                    v3_r;
  logic [ProdW-1:0]        inter3_r;
  logic signed [ProdW-1:0] ad_r, at_r;

  // Union.
  logic                   v4_r;
  logic [ProdW-1:0]       inter4_r;
  logic signed [UniW-1:0] uni_r, uni_nxt;

  // Divider stages; index 0 is loaded by the range check.
  logic                vld_r   [0:FracW];
  logic [RemW-1:0]     rem_r   [0:FracW];
  logic [RemW-1:0]     dsr_r   [0:FracW];
  logic [FracW-1:0]    quo_r   [0:FracW];
  logic                usediv_r[0:FracW];
  biou_pkg::out_word_t fix_r   [0:FracW];

  logic [RemW-1:0]     rem_nxt[0:FracW];
  logic [FracW-1:0]    quo_nxt[0:FracW];
  logic                usediv_nxt;
  biou_pkg::out_word_t fix_nxt;

  logic                out_valid_r;
  biou_pkg::out_word_t out_data_r, out_data_nxt;

  always_comb begin
    biou_pkg::coord_t        lo_x, lo_y, hi_x, hi_y;
    logic signed [DiffW-1:0] sw, sh;
    lo_x = (in_r.det_left > in_r.trk_left) ? in_r.det_left : in_r.trk_left;
    lo_y = (in_r.det_top > in_r.trk_top) ? in_r.det_top : in_r.trk_top;
    hi_x = (in_r.det_right < in_r.trk_right) ? in_r.det_right : in_r.trk_right;
    hi_y = (in_r.det_bottom < in_r.trk_bottom) ? in_r.det_bottom : in_r.trk_bottom;
    sw = DiffW'(hi_x) - DiffW'(lo_x);
    sh = DiffW'(hi_y) - DiffW'(lo_y);
    iw_nxt = sw[DiffW-1] ? '0 : DiffW'(sw);
    ih_nxt = sh[DiffW-1] ? '0 : DiffW'(sh);
    dw_nxt = DiffW'(in_r.det_right) - DiffW'(in_r.det_left);
    dh_nxt = DiffW'(in_r.det_bottom) - DiffW'(in_r.det_top);
    tw_nxt = DiffW'(in_r.trk_right) - DiffW'(in_r.trk_left);
    th_nxt = DiffW'(in_r.trk_bottom) - DiffW'(in_r.trk_top);
    v2_nxt = v1_r;
  end

  always_comb begin
    uni_nxt = UniW'(ad_r) + UniW'(at_r) - $signed({2'b00, inter3_r});
  end

  always_comb begin
    logic [UniW-1:0] inter_ext;
    logic            bad;
    inter_ext = {2'b00, inter4_r};
    bad = uni_r[UniW-1] || (uni_r == '0);
    fix_nxt.overlap_ratio = biou_pkg::RatioOne;
    fix_nxt.ratio_invalid = 1'b0;
    usediv_nxt = 1'b0;
    priority if (bad) begin
      fix_nxt.overlap_ratio = biou_pkg::RatioZero;
      fix_nxt.ratio_invalid = 1'b1;
    end else if (inter_ext == $unsigned(uni_r)) begin
      fix_nxt.ratio_invalid = 1'b0;
    end else if (inter_ext > $unsigned(uni_r)) begin
      fix_nxt.ratio_invalid = 1'b1;
    end else begin
      usediv_nxt = 1'b1;
    end
  end

  always_comb begin
    logic [RemW:0] shifted;
    rem_nxt[0] = RemW'(inter4_r);
    quo_nxt[0] = '0;
    for (int k = 0; k < FracW; k++) begin
      shifted = {rem_r[k], 1'b0};
      if (shifted >= {1'b0, dsr_r[k]}) begin
        rem_nxt[k+1] = RemW'(shifted - {1'b0, dsr_r[k]});
        quo_nxt[k+1] = {quo_r[k][FracW-2:0], 1'b1};
      end else begin
        rem_nxt[k+1] = shifted[RemW-1:0];
        quo_nxt[k+1] = {quo_r[k][FracW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (usediv_r[FracW]) begin
      out_data_nxt.overlap_ratio = {1'b0, quo_r[FracW]};
      out_data_nxt.ratio_invalid = 1'b0;
    end else begin
      out_data_nxt = fix_r[FracW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int k = 0; k <= FracW; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v2_nxt;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vld_r[0] <= v4_r;
      for (int k = 0; k < FracW; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_valid_r <= vld_r[FracW];
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_data;
    iw_r     <= iw_nxt;
    ih_r     <= ih_nxt;
    dw_r     <= dw_nxt;
    dh_r     <= dh_nxt;
    tw_r     <= tw_nxt;
    th_r     <= th_nxt;
    inter3_r <= ProdW'(iw_r) * ProdW'(ih_r);
    ad_r     <= ProdW'(dw_r) * ProdW'(dh_r);
    at_r     <= ProdW'(tw_r) * ProdW'(th_r);
    inter4_r <= inter3_r;
    uni_r    <= uni_nxt;
    rem_r[0]    <= rem_nxt[0];
    dsr_r[0]    <= uni_r[RemW-1:0];
    quo_r[0]    <= quo_nxt[0];
    usediv_r[0] <= usediv_nxt;
    fix_r[0]    <= fix_nxt;
    for (int k = 0; k < FracW; k++) begin
      rem_r[k+1]    <= rem_nxt[k+1];
      dsr_r[k+1]    <= dsr_r[k];
      quo_r[k+1]    <= quo_nxt[k+1];
      usediv_r[k+1] <= usediv_r[k];
      fix_r[k+1]    <= fix_r[k];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/biou_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for box_intersection_over_union: watches both channels, predicts
// each ratio word from the accepted box pair word and compares field by field.
// Depends on biou_pkg for the word types and the fraction width.
module biou_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  biou_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  biou_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  words_pending,
  output int                  words_checked,
  output int                  flagged_count,
  output int                  exact_count
);

  biou_pkg::out_word_t expected_ratios[$];

  function automatic biou_pkg::out_word_t overlap_predict(biou_pkg::in_word_t w);
    longint              dl, dt, dr, db, tl, tt, tr, tb;
    longint              iw, ih, inter_area, det_area, trk_area, joint_area;
    biou_pkg::out_word_t r;
    dl = $signed(w.det_left);
    dt = $signed(w.det_top);
    dr = $signed(w.det_right);
    db = $signed(w.det_bottom);
    tl = $signed(w.trk_left);
    tt = $signed(w.trk_top);
    tr = $signed(w.trk_right);
    tb = $signed(w.trk_bottom);
    iw = ((dr < tr) ? dr : tr) - ((dl > tl) ? dl : tl);
    ih = ((db < tb) ? db : tb) - ((dt > tt) ? dt : tt);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter_area = iw * ih;
    det_area   = (dr - dl) * (db - dt);
    trk_area   = (tr - tl) * (tb - tt);
    joint_area = det_area + trk_area - inter_area;
    r.ratio_invalid = 1'b0;
    if (joint_area <= 0) begin
      r.overlap_ratio = biou_pkg::RatioZero;
      r.ratio_invalid = 1'b1;
    end else if (inter_area == joint_area) begin
      r.overlap_ratio = biou_pkg::RatioOne;
    end else if (inter_area > joint_area) begin
      r.overlap_ratio = biou_pkg::RatioOne;
      r.ratio_invalid = 1'b1;
    end else begin
      r.overlap_ratio =
        biou_pkg::ratio_t'((inter_area <<< biou_pkg::FracW) / joint_area);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    biou_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_ratios.size() == 0) begin
          $error("unexpected result word: overlap_ratio %0d, ratio_invalid %0d",
                 out_data.overlap_ratio, out_data.ratio_invalid);
          fail_count++;
        end else begin
          want = expected_ratios.pop_front();
          words_checked++;
          if (out_data.overlap_ratio !== want.overlap_ratio) begin
            $error("overlap_ratio: expected %0d, actual %0d",
                   want.overlap_ratio, out_data.overlap_ratio);
            fail_count++;
          end
          if (out_data.ratio_invalid !== want.ratio_invalid) begin
            $error("ratio_invalid: expected %0d, actual %0d",
                   want.ratio_invalid, out_data.ratio_invalid);
            fail_count++;
          end
          if (want.ratio_invalid) flagged_count++;
          else if (want.overlap_ratio == biou_pkg::RatioOne) exact_count++;
        end
      end
      if (start && !busy) begin
        expected_ratios.insert(expected_ratios.size(), overlap_predict(in_data));
      end
    end
    words_pending = expected_ratios.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the box_intersection_over_union testbench: clock, reset, directed and
// random box pair words with random gaps, and the verdict from biou_checker.
// Depends on biou_pkg, box_intersection_over_union and biou_checker.
module tb;

  localparam int TxWords     = 800;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  biou_pkg::in_word_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  biou_pkg::out_word_t out_data;

  int fail_count;
  int words_pending;
  int words_checked;
  int flagged_count;
  int exact_count;
  int cycle_count = 0;
  int words_sent  = 0;
  int steady_left = 0;

  always #1 clk = ~clk;

  box_intersection_over_union u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  biou_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .flagged_count (flagged_count),
    .exact_count   (exact_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic biou_pkg::in_word_t pack_pair(int d[4], int t[4]);
    biou_pkg::in_word_t w;
    w.det_left   = biou_pkg::coord_t'(d[0]);
    w.det_top    = biou_pkg::coord_t'(d[1]);
    w.det_right  = biou_pkg::coord_t'(d[2]);
    w.det_bottom = biou_pkg::coord_t'(d[3]);
    w.trk_left   = biou_pkg::coord_t'(t[0]);
    w.trk_top    = biou_pkg::coord_t'(t[1]);
    w.trk_right  = biou_pkg::coord_t'(t[2]);
    w.trk_bottom = biou_pkg::coord_t'(t[3]);
    return w;
  endfunction

  // Long runs without gaps are mixed in so back-to-back words are covered too.
  task automatic send_word(input biou_pkg::in_word_t w);
    int gap;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
  endtask

  task automatic send_boxes(input int dl, dt, dr, db, tl, tt, tr, tb);
    int d[4];
    int t[4];
    d = '{dl, dt, dr, db};
    t = '{tl, tt, tr, tb};
    send_word(pack_pair(d, t));
  endtask

  task automatic pick_box(input int max_size, output int box[4]);
    int w;
    int h;
    w = $urandom_range(0, max_size);
    h = $urandom_range(0, max_size);
    box[0] = int'($urandom_range(0, 65535 - w)) - 32768;
    box[1] = int'($urandom_range(0, 65535 - h)) - 32768;
    box[2] = box[0] + w;
    box[3] = box[1] + h;
  endtask

  task automatic jitter_box(input int src[4], input int span, output int dst[4]);
    int tmp;
    for (int i = 0; i < 4; i++) begin
      dst[i] = clamp_coord(src[i] + int'($urandom_range(0, 2 * span)) - span);
    end
    if (dst[0] > dst[2]) begin
      tmp = dst[0]; dst[0] = dst[2]; dst[2] = tmp;
    end
    if (dst[1] > dst[3]) begin
      tmp = dst[1]; dst[1] = dst[3]; dst[3] = tmp;
    end
  endtask

  // Mostly well-formed overlapping pairs, plus raw words, swapped corners
  // and boxes of zero width or height.
  task automatic random_pair(output biou_pkg::in_word_t w);
    int d[4];
    int t[4];
    int kind;
    int sel;
    int tmp;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      pick_box(255, d);
      jitter_box(d, 64, t);
    end else if (kind < 60) begin
      pick_box(65535, d);
      jitter_box(d, 16384, t);
    end else if (kind < 70) begin
      pick_box(1023, d);
      t = d;
      if ($urandom_range(0, 1)) begin
        t[0] = d[0] + $urandom_range(0, (d[2] - d[0]) / 2);
        t[2] = d[2] - $urandom_range(0, (d[2] - d[0]) / 2);
        t[1] = d[1] + $urandom_range(0, (d[3] - d[1]) / 2);
        t[3] = d[3] - $urandom_range(0, (d[3] - d[1]) / 2);
      end
    end else if (kind < 85) begin
      for (int i = 0; i < 4; i++) begin
        d[i] = int'(biou_pkg::coord_t'($urandom()));
        t[i] = int'(biou_pkg::coord_t'($urandom()));
      end
    end else if (kind < 95) begin
      pick_box(255, d);
      jitter_box(d, 64, t);
      sel = $urandom_range(1, 15);
      if (sel[0]) begin
        tmp = d[0]; d[0] = d[2]; d[2] = tmp;
      end
      if (sel[1]) begin
        tmp = d[1]; d[1] = d[3]; d[3] = tmp;
      end
      if (sel[2]) begin
        tmp = t[0]; t[0] = t[2]; t[2] = tmp;
      end
      if (sel[3]) begin
        tmp = t[1]; t[1] = t[3]; t[3] = tmp;
      end
    end else begin
      pick_box(255, d);
      jitter_box(d, 64, t);
      case ($urandom_range(0, 3))
        0: d[2] = d[0];
        1: d[3] = d[1];
        2: t[2] = t[0];
        default: begin
          d[2] = d[0];
          t[3] = t[1];
        end
      endcase
    end
    w = pack_pair(d, t);
  endtask

  initial begin
    biou_pkg::in_word_t pair_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_boxes(0, 0, 10, 10, 0, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 20, 20, 30, 30);
    send_boxes(0, 0, 10, 10, 10, 0, 20, 10);
    send_boxes(0, 0, 10, 10, 5, 5, 15, 15);
    send_boxes(0, 0, 100, 100, 10, 10, 20, 20);
    send_boxes(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_boxes(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
    send_boxes(-32768, -32768, 32767, 32767, -32768, -32768, 0, 0);
    send_boxes(5, 5, 5, 5, 5, 5, 5, 5);
    send_boxes(0, 0, 0, 10, 3, 0, 3, 10);
    send_boxes(10, 0, 0, 10, 0, 0, 3, 3);
    send_boxes(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768);
    send_boxes(10, 10, 0, 0, 5, 0, 0, 5);
    send_boxes(10, 0, 0, 10, 0, 0, 10, 10);
    send_boxes(-32768, 0, 32767, 1, -32768, 0, 32767, 1);
    send_boxes(-32768, -32768, -32767, -32767, 32766, 32766, 32767, 32767);
    send_boxes(-1, -1, -1, -1, -1, -1, -1, -1);
    send_boxes(0, 0, 1000, 1000, 0, 0, 1000, 999);
    send_boxes(0, 0, 10, 10, 0, 0, 10, 5);
    send_boxes(0, 0, 3, 1, 1, 0, 2, 1);
    send_boxes(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768);

    for (int n = 0; n < TxWords; n++) begin
      random_pair(pair_word);
      send_word(pair_word);
    end
    start <= 1'b0;

    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d box pair words: corner cases, then overlapping, nested, raw,",
             words_sent);
    $display("inverted and degenerate pairs; %0d ratios checked, %0d exact, %0d invalid.",
             words_checked, exact_count, flagged_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/biou_pkg.sv
rtl/box_intersection_over_union.sv
tb/biou_checker.sv
tb/tb.sv
